// File: rtl/dsbd_pkg.sv
// Shared constants, types and the exp(-x) step table for the detection score and box decode.
// No dependencies; every other file of the block imports this package.
package dsbd_pkg;

    // Field widths.
    localparam int LOGIT_W   = 16;
    localparam int PHR_W     = 7;
    localparam int BOX_W     = 16;
    localparam int SIZE_W    = 14;
    localparam int COORD_W   = 18;
    localparam int PROB_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Phrase numbers at or above this count lie outside every span.
    localparam int MAX_PHRASES = 128;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Sigmoid datapath: one stage per magnitude bit, one per quotient bit.
    localparam int EXP_STEPS  = 12;
    localparam int DIV_STEPS  = 17;
    localparam int MAG_W      = LOGIT_W + 1;
    localparam int E_W        = 25;                 // exp(-a) in Q0.24, up to 1.0
    localparam int C_W        = 24;                 // step constants in Q0.24
    localparam int D_W        = E_W + 1;            // 1.0 + exp(-a)
    localparam int R_W        = E_W;                // remainder stays below the divisor
    localparam int NUM_W      = R_W - 1 + DIV_STEPS; // dividend width
    localparam int NUM_STAGES = 1 + EXP_STEPS + 1 + DIV_STEPS;

    localparam logic [MAG_W-1:0] LOGIT_SPAN = MAG_W'(1) << LOGIT_W;
    localparam logic [MAG_W-1:0] EXP_LIMIT  = MAG_W'(1) << EXP_STEPS;
    localparam logic [E_W-1:0]   E_ONE      = E_W'(1) << C_W;
    localparam logic [NUM_W-1:0] NUM_ONE    = NUM_W'(1) << (NUM_W - 1);
    localparam logic [PROB_W-1:0] PROB_MAX  = '1;

    // Box scaling: Q0.16 times pixels times 16, with the doubled center.
    localparam int BOX_SHIFT = 13;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(8192);
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_SCORE_THRESHOLD = 2'd2
    } dsbd_cfg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;      // already clamped to 1..8192
        logic [SIZE_W-1:0] height;
        logic [PROB_W-1:0] threshold;
    } dsbd_cfg_t;

    // One classified token as it sits in the queue.
    typedef struct packed {
        logic                 neg;
        logic                 zero_e;   // magnitude of 16.0 or more: exp term is zero
        logic [EXP_STEPS-1:0] abits;
        logic                 span;
        logic [PHR_W-1:0]     phr;
        logic                 last;
        logic [BOX_W-1:0]     cx;
        logic [BOX_W-1:0]     cy;
        logic [BOX_W-1:0]     bw;
        logic [BOX_W-1:0]     bh;
    } dsbd_entry_t;

    // Sideband that travels with a token through the sigmoid pipeline.
    typedef struct packed {
        logic                 neg;
        logic [EXP_STEPS-1:0] abits;
        logic                 span;
        logic [PHR_W-1:0]     phr;
        logic                 last;
        logic [COORD_W-1:0]   left;
        logic [COORD_W-1:0]   top;
        logic [COORD_W-1:0]   right;
        logic [COORD_W-1:0]   bottom;
    } dsbd_side_t;

    // exp(-2^(k-8)) in Q0.24 for magnitude bit k.
    function automatic logic [C_W-1:0] exp_const(input logic [3:0] k);
        logic [C_W-1:0] c;
        case (k)
            4'd0:    c = 24'd16711808;
            4'd1:    c = 24'd16646654;
            4'd2:    c = 24'd16517109;
            4'd3:    c = 24'd16261035;
            4'd4:    c = 24'd15760736;
            4'd5:    c = 24'd14805840;
            4'd6:    c = 24'd13066109;
            4'd7:    c = 24'd10175896;
            4'd8:    c = 24'd6171993;
            4'd9:    c = 24'd2270549;
            4'd10:   c = 24'd307286;
            4'd11:   c = 24'd5628;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/dsbd_front.sv
// Front of the decode: takes input items and classifies each token for the queue.
// Depends on dsbd_pkg; feeds dsbd_queue.
module dsbd_front
    import dsbd_pkg::*;
(
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [LOGIT_W-1:0] s_logit,
    input  logic                     s_in_phrase,
    input  logic [PHR_W-1:0]         s_phrase_index,
    input  logic                     s_last_token,
    input  logic [BOX_W-1:0]         s_box_cx,
    input  logic [BOX_W-1:0]         s_box_cy,
    input  logic [BOX_W-1:0]         s_box_w,
    input  logic [BOX_W-1:0]         s_box_h,
    input  logic                     q_full,
    output logic                     q_push,
    output dsbd_entry_t              q_entry
);

    logic [LOGIT_W-1:0] raw;
    logic               neg;
    logic [MAG_W-1:0]   mag;

    assign raw = $unsigned(s_logit);
    assign neg = raw[LOGIT_W-1];
    // Magnitude of the Q8.8 logit; the most negative code gives 128.0.
    assign mag = neg ? (LOGIT_SPAN - MAG_W'(raw)) : MAG_W'(raw);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_entry.neg    = neg;
        q_entry.zero_e = (mag >= EXP_LIMIT);
        q_entry.abits  = mag[EXP_STEPS-1:0];
        q_entry.span   = s_in_phrase && ((PHR_W + 2)'(s_phrase_index) < (PHR_W + 2)'(MAX_PHRASES));
        q_entry.phr    = s_phrase_index;
        q_entry.last   = s_last_token;
        q_entry.cx     = s_box_cx;
        q_entry.cy     = s_box_cy;
        q_entry.bw     = s_box_w;
        q_entry.bh     = s_box_h;
    end

endmodule

// File: rtl/dsbd_queue.sv
// Short token queue that decouples the front from the back of the decode.
// Depends on dsbd_pkg for the entry type and depth.
module dsbd_queue
    import dsbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  dsbd_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output dsbd_entry_t head
);

    dsbd_entry_t       mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("queue read while empty");

endmodule

// File: rtl/dsbd_back.sv
// Back of the decode: sigmoid pipeline, box scaling, per-query reduction and result register.
// Depends on dsbd_pkg; reads tokens from dsbd_queue.
module dsbd_back
    import dsbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dsbd_cfg_t          cfg,
    input  logic               q_empty,
    input  dsbd_entry_t        q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_left,
    output logic [COORD_W-1:0] m_top,
    output logic [COORD_W-1:0] m_right,
    output logic [COORD_W-1:0] m_bottom,
    output logic [PROB_W-1:0]  m_score,
    output logic [PHR_W-1:0]   m_phrase
);

    localparam int LAST = NUM_STAGES - 1;

    typedef struct packed {
        logic [R_W-1:0]       r;
        logic [DIV_STEPS-1:0] nq;
    } dsbd_div_t;

    function automatic logic [COORD_W-1:0] low_edge(input logic [BOX_W-1:0] c,
                                                    input logic [BOX_W-1:0] s,
                                                    input logic [SIZE_W-1:0] size);
        logic [BOX_W:0]          twice;
        logic [BOX_W:0]          diff;
        logic [BOX_W+SIZE_W:0]   prod;
        twice = {c, 1'b0};
        diff  = twice - (BOX_W + 1)'(s);
        prod  = (BOX_W + SIZE_W + 1)'(diff) * (BOX_W + SIZE_W + 1)'(size);
        if (twice <= (BOX_W + 1)'(s)) begin
            return '0;
        end
        return COORD_W'(prod >> BOX_SHIFT);
    endfunction

    function automatic logic [COORD_W-1:0] high_edge(input logic [BOX_W-1:0] c,
                                                     input logic [BOX_W-1:0] s,
                                                     input logic [SIZE_W-1:0] size);
        logic [BOX_W+1:0]        sum;
        logic [BOX_W+SIZE_W+1:0] prod;
        logic [BOX_W+SIZE_W+1:0] v;
        logic [BOX_W+SIZE_W+1:0] lim;
        sum  = (BOX_W + 2)'({c, 1'b0}) + (BOX_W + 2)'(s);
        prod = (BOX_W + SIZE_W + 2)'(sum) * (BOX_W + SIZE_W + 2)'(size);
        v    = prod >> BOX_SHIFT;
        lim  = (BOX_W + SIZE_W + 2)'({size, 4'b0000});
        return (v > lim) ? COORD_W'(lim) : COORD_W'(v);
    endfunction

    function automatic logic [E_W-1:0] exp_step(input logic [E_W-1:0] e,
                                                 input logic [C_W-1:0] c);
        logic [E_W+C_W-1:0] prod;
        prod = (E_W + C_W)'(e) * (E_W + C_W)'(c) + ((E_W + C_W)'(1) << (C_W - 1));
        return E_W'(prod >> C_W);
    endfunction

    function automatic dsbd_div_t div_step(input logic [R_W-1:0] r,
                                           input logic [DIV_STEPS-1:0] nq,
                                           input logic [D_W-1:0] d);
        logic [D_W-1:0] trial;
        logic           ge;
        dsbd_div_t      res;
        trial  = {r, nq[DIV_STEPS-1]};
        ge     = (trial >= d);
        res.r  = ge ? R_W'(trial - d) : R_W'(trial);
        res.nq = {nq[DIV_STEPS-2:0], ge};
        return res;
    endfunction

    // Pipeline stall: everything advances unless a result is held back.
    logic adv;

    logic [LAST:0]        valid_reg;
    dsbd_side_t           side_reg  [NUM_STAGES];
    dsbd_side_t           side_next [NUM_STAGES];
    logic [E_W-1:0]       e_reg     [EXP_STEPS+1];
    logic [E_W-1:0]       e_next    [EXP_STEPS+1];
    logic [D_W-1:0]       d_reg     [DIV_STEPS+1];
    logic [D_W-1:0]       d_next    [DIV_STEPS+1];
    logic [R_W-1:0]       r_reg     [DIV_STEPS+1];
    logic [R_W-1:0]       r_next    [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] nq_reg    [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] nq_next   [DIV_STEPS+1];

    logic [D_W-1:0]   div_d;
    logic [NUM_W-1:0] div_num;

    assign adv   = !m_valid || m_ready;
    assign q_pop = adv && !q_empty;

    always_comb begin
        dsbd_div_t dv;
        side_next[0].neg    = q_head.neg;
        side_next[0].abits  = q_head.abits;
        side_next[0].span   = q_head.span;
        side_next[0].phr    = q_head.phr;
        side_next[0].last   = q_head.last;
        side_next[0].left   = low_edge(q_head.cx, q_head.bw, cfg.width);
        side_next[0].top    = low_edge(q_head.cy, q_head.bh, cfg.height);
        side_next[0].right  = high_edge(q_head.cx, q_head.bw, cfg.width);
        side_next[0].bottom = high_edge(q_head.cy, q_head.bh, cfg.height);
        for (int s = 1; s < NUM_STAGES; s++) begin
            side_next[s] = side_reg[s-1];
        end

        e_next[0] = q_head.zero_e ? '0 : E_ONE;
        for (int k = 0; k < EXP_STEPS; k++) begin
            e_next[k+1] = side_reg[k].abits[k] ? exp_step(e_reg[k], exp_const(4'(k)))
                                               : e_reg[k];
        end

        // Positive logit: 1 / (1 + e); negative: e / (1 + e), both rounded.
        div_d   = D_W'(E_ONE) + D_W'(e_reg[EXP_STEPS]);
        div_num = side_reg[EXP_STEPS].neg
                ? (NUM_W'(e_reg[EXP_STEPS]) << PROB_W) + NUM_W'(div_d >> 1)
                : NUM_ONE + NUM_W'(div_d >> 1);
        d_next[0]  = div_d;
        r_next[0]  = R_W'(div_num >> DIV_STEPS);
        nq_next[0] = div_num[DIV_STEPS-1:0];
        for (int j = 0; j < DIV_STEPS; j++) begin
            dv          = div_step(r_reg[j], nq_reg[j], d_reg[j]);
            d_next[j+1] = d_reg[j];
            r_next[j+1] = dv.r;
            nq_next[j+1] = dv.nq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LAST-1:0], q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_next;
            e_reg    <= e_next;
            d_reg    <= d_next;
            r_reg    <= r_next;
            nq_reg   <= nq_next;
        end
    end

    // Per-query reduction at the end of the pipeline.
    dsbd_side_t        tail;
    logic [PROB_W-1:0] prob;
    logic [PROB_W-1:0] max_prob_reg, max_prob_next;
    logic [PROB_W-1:0] best_span_reg, best_span_next;
    logic              have_span_reg, have_span_next;
    logic [PHR_W-1:0]  best_phrase_reg, best_phrase_next;
    logic              fire;
    logic              keep;

    logic               out_valid_reg;
    logic [COORD_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [PROB_W-1:0]  score_reg;
    logic [PHR_W-1:0]   phrase_reg;

    assign tail = side_reg[LAST];
    assign prob = (!tail.neg && nq_reg[DIV_STEPS][DIV_STEPS-1]) ? PROB_MAX
                                                                 : nq_reg[DIV_STEPS][PROB_W-1:0];
    assign fire = adv && valid_reg[LAST];

    always_comb begin
        max_prob_next    = (prob > max_prob_reg) ? prob : max_prob_reg;
        best_span_next   = best_span_reg;
        have_span_next   = have_span_reg;
        best_phrase_next = best_phrase_reg;
        if (tail.span && (!have_span_reg || prob > best_span_reg)) begin
            best_span_next   = prob;
            have_span_next   = 1'b1;
            best_phrase_next = tail.phr;
        end
        keep = tail.last && (max_prob_next > cfg.threshold);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_prob_reg    <= '0;
            best_span_reg   <= '0;
            have_span_reg   <= 1'b0;
            best_phrase_reg <= '0;
        end else if (fire) begin
            if (tail.last) begin
                max_prob_reg    <= '0;
                best_span_reg   <= '0;
                have_span_reg   <= 1'b0;
                best_phrase_reg <= '0;
            end else begin
                max_prob_reg    <= max_prob_next;
                best_span_reg   <= best_span_next;
                have_span_reg   <= have_span_next;
                best_phrase_reg <= best_phrase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= valid_reg[LAST] && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && keep) begin
            left_reg   <= tail.left;
            top_reg    <= tail.top;
            right_reg  <= tail.right;
            bottom_reg <= tail.bottom;
            score_reg  <= max_prob_next;
            phrase_reg <= best_phrase_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_left   = left_reg;
    assign m_top    = top_reg;
    assign m_right  = right_reg;
    assign m_bottom = bottom_reg;
    assign m_score  = score_reg;
    assign m_phrase = phrase_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_score > cfg.threshold))
        else $error("detection issued at or below the score threshold");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while the result was held");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !have_span_reg |-> (best_phrase_reg == '0))
        else $error("phrase recorded without a span token");

endmodule

// File: rtl/detection_score_box_decode_core.sv
// Throughput: one item per cycle while no result is held at the output; the sigmoid
// pipeline has 31 stages (12 multiply steps, 17 restoring-divide steps) and is
// followed by the result register.
// Reset (aresetn low at a clock edge) empties the queue and pipeline, clears the
// per-query state and returns the registers to width 1, height 1, threshold 0.
// Depends on dsbd_pkg, dsbd_front, dsbd_queue and dsbd_back.
module detection_score_box_decode_core
    import dsbd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    // Configuration writes, to be made only while the block is idle; the block does not enforce it.
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,

    // Token items.
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [LOGIT_W-1:0] s_logit,
    input  logic                      s_in_phrase,
    input  logic [PHR_W-1:0]          s_phrase_index,
    input  logic                      s_last_token,
    input  logic [BOX_W-1:0]          s_box_cx,
    input  logic [BOX_W-1:0]          s_box_cy,
    input  logic [BOX_W-1:0]          s_box_w,
    input  logic [BOX_W-1:0]          s_box_h,

    // Detection items, at most one per query.
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [COORD_W-1:0]        m_left,
    output logic [COORD_W-1:0]        m_top,
    output logic [COORD_W-1:0]        m_right,
    output logic [COORD_W-1:0]        m_bottom,
    output logic [PROB_W-1:0]         m_score,
    output logic [PHR_W-1:0]          m_phrase
);

    // Sizes of 0 act as 1 and sizes above 8192 act as 8192.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_MIN;
        end
        return (v > SIZE_MAX) ? SIZE_MAX : v;
    endfunction

    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;
    logic [PROB_W-1:0] score_threshold_reg;
    dsbd_cfg_t         cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= SIZE_MIN;
            image_height_reg    <= SIZE_MIN;
            score_threshold_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (dsbd_cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_wdata[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:    image_height_reg    <= cfg_wdata[SIZE_W-1:0];
                CFG_SCORE_THRESHOLD: score_threshold_reg <= cfg_wdata[PROB_W-1:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // The user changes the configuration only while no item is in flight (the block does not
    // enforce it), so the back reads these values directly at whichever stage needs them.
    assign cfg.width     = clamp_size(image_width_reg);
    assign cfg.height    = clamp_size(image_height_reg);
    assign cfg.threshold = score_threshold_reg;

    logic        q_full;
    logic        q_push;
    dsbd_entry_t q_entry;
    logic        q_empty;
    logic        q_pop;
    dsbd_entry_t q_head;

    // The front classifies each token (sign, exp magnitude bits, span membership)
    // and drops it into the queue in the cycle it is accepted.
    dsbd_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_logit        (s_logit),
        .s_in_phrase    (s_in_phrase),
        .s_phrase_index (s_phrase_index),
        .s_last_token   (s_last_token),
        .s_box_cx       (s_box_cx),
        .s_box_cy       (s_box_cy),
        .s_box_w        (s_box_w),
        .s_box_h        (s_box_h),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    // The queue keeps accepting items while the back is stalled by a held result, until it is full.
    dsbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    // The back scales the box as a token leaves the queue, runs the sigmoid, and
    // reduces each query into at most one detection held in the result register.
    dsbd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_left   (m_left),
        .m_top    (m_top),
        .m_right  (m_right),
        .m_bottom (m_bottom),
        .m_score  (m_score),
        .m_phrase (m_phrase)
    );

endmodule
